@@ design/ohs_pkg.sv @@
package ohs_pkg;

   // The slot count must be a power of two: probe positions wrap by truncation.
   localparam int TABLE_SIZE = 256;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);
   localparam int KEY_W      = 32;
   localparam int COUNT_W    = 9;

   localparam logic [KEY_W-1:0] SLOT_EMPTY   = '0;
   localparam logic [KEY_W-1:0] SLOT_VACATED = KEY_W'(1);

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic               success;
      logic [COUNT_W-1:0] member_count;
   } rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
   } store_req_type;

endpackage

@@ design/ohs_slot_store.sv @@
module ohs_slot_store
   import ohs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  store_req_type     store_req,
   output logic [KEY_W-1:0]  rd_data
);

   logic [KEY_W-1:0]      mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] valid_ff;
   logic [KEY_W-1:0]      rd_word_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_word_ff <= mem[store_req.rd_addr];
      end
   end

   // A slot never written since reset reads as empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (store_req.wr_en) begin
            valid_ff[store_req.wr_addr] <= 1'b1;
         end
         if (store_req.rd_en) begin
            rd_valid_ff <= valid_ff[store_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : SLOT_EMPTY;

endmodule

@@ design/open_addressing_hash_set.sv @@
// Channel    Ports                         Direction  Transfer
// request    start, busy, req_data          in         start high while busy is low
// response   rsp_strobe, rsp_data           out        one cycle per strobe, no stall
//
// A request for key 0 or 1, an unused opcode, or a lookup or remove on an empty
// set is answered in the cycle after it is taken. Any other request walks its
// probe path one slot per cycle, limited by the single read port of the slot
// store: a walk takes 1 to TABLE_SIZE probes, and the next request can be taken
// in the cycle of the walk's response.
// Reset is synchronous and clears the set without a sweep of the store.
// The receiver cannot stall, so busy depends only on an open probe walk.
module open_addressing_hash_set
   import ohs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

   // Control and flag state.
   state_type          state_ff,      state_in;
   logic               zero_ff,       zero_in;
   logic               one_ff,        one_in;
   logic [COUNT_W-1:0] count_ff,      count_in;
   logic               rsp_valid_ff,  rsp_valid_in;

   // Probe walk context.
   logic [1:0]         op_ff,         op_in;
   logic [KEY_W-1:0]   key_ff,        key_in;
   logic [ADDR_W-1:0]  pos_ff,        pos_in;
   logic [ADDR_W-1:0]  step_ff,       step_in;
   logic [ADDR_W-1:0]  probe_cnt_ff,  probe_cnt_in;
   logic               free_seen_ff,  free_seen_in;
   logic [ADDR_W-1:0]  free_pos_ff,   free_pos_in;
   rsp_type            rsp_ff,        rsp_in;

   store_req_type      store_req;
   logic [KEY_W-1:0]   slot_word;

   logic               accept;
   logic               small_key;
   logic               is_empty;
   logic               is_vacated;
   logic               is_match;
   logic               last_probe;
   logic [ADDR_W-1:0]  next_pos;
   logic [ADDR_W-1:0]  free_slot;

   ohs_slot_store u_slot_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_data   (slot_word)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign small_key  = (req_data.key[KEY_W-1:1] == '0);

   // Classification of the slot word that the store returns this cycle.
   assign is_empty   = (slot_word == SLOT_EMPTY);
   assign is_vacated = (slot_word == SLOT_VACATED);
   assign is_match   = (slot_word == key_ff);
   assign last_probe = (probe_cnt_ff == ADDR_W'(TABLE_SIZE - 1));
   assign next_pos   = pos_ff + step_ff;
   // The first free slot on the path is the insert target; the current slot
   // counts as free when no earlier vacated slot was seen.
   assign free_slot  = free_seen_ff ? free_pos_ff : pos_ff;

   always_comb begin
      state_in      = state_ff;
      zero_in       = zero_ff;
      one_in        = one_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      probe_cnt_in  = probe_cnt_ff;
      free_seen_in  = free_seen_ff;
      free_pos_in   = free_pos_ff;

      store_req          = '0;
      store_req.rd_addr  = req_data.key[ADDR_W-1:0];
      store_req.wr_addr  = pos_ff;
      store_req.wr_data  = SLOT_VACATED;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Load the walk context; it is used only if a probe walk starts.
               op_in         = req_data.opcode;
               key_in        = req_data.key;
               pos_in        = req_data.key[ADDR_W-1:0];
               step_in       = {req_data.key[ADDR_W-2:0], 1'b1};
               probe_cnt_in  = '0;
               free_seen_in  = 1'b0;
               rsp_in.success = 1'b0;
               case (req_data.opcode)
                  OP_LOOKUP: begin
                     if (count_ff != '0 && small_key) begin
                        rsp_in.success = req_data.key[0] ? one_ff : zero_ff;
                     end else if (count_ff != '0) begin
                        state_in = ST_PROBE;
                     end
                  end
                  OP_INSERT: begin
                     // Inserts of keys 0 and 1 always succeed; the count moves
                     // only when the flag was clear.
                     if (small_key) begin
                        rsp_in.success = 1'b1;
                        if (req_data.key[0]) begin
                           one_in = 1'b1;
                           if (!one_ff) begin
                              count_in = count_ff + 1'b1;
                           end
                        end else begin
                           zero_in = 1'b1;
                           if (!zero_ff) begin
                              count_in = count_ff + 1'b1;
                           end
                        end
                     end else begin
                        state_in = ST_PROBE;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff != '0 && small_key) begin
                        if (req_data.key[0] && one_ff) begin
                           one_in         = 1'b0;
                           count_in       = count_ff - 1'b1;
                           rsp_in.success = 1'b1;
                        end else if (!req_data.key[0] && zero_ff) begin
                           zero_in        = 1'b0;
                           count_in       = count_ff - 1'b1;
                           rsp_in.success = 1'b1;
                        end
                     end else if (count_ff != '0) begin
                        state_in = ST_PROBE;
                     end
                  end
                  default: begin
                  end
               endcase
               store_req.rd_en = (state_in == ST_PROBE);
               if (state_in == ST_IDLE) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.member_count = count_in;
               end
            end
         end
         ST_PROBE: begin
            if (is_match) begin
               // Key found: lookup and insert succeed; remove leaves a tombstone.
               rsp_in.success = 1'b1;
               if (op_ff == OP_REMOVE) begin
                  store_req.wr_en   = 1'b1;
                  store_req.wr_addr = pos_ff;
                  store_req.wr_data = SLOT_VACATED;
                  count_in          = count_ff - 1'b1;
               end
               state_in = ST_IDLE;
            end else if (is_empty || last_probe) begin
               // The key is absent. An insert takes the first free slot seen,
               // and fails only when the whole path holds keys.
               rsp_in.success = 1'b0;
               if (op_ff == OP_INSERT && (free_seen_ff || is_empty || is_vacated)) begin
                  store_req.wr_en   = 1'b1;
                  store_req.wr_addr = free_slot;
                  store_req.wr_data = key_ff;
                  count_in          = count_ff + 1'b1;
                  rsp_in.success    = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               if (is_vacated && !free_seen_ff) begin
                  free_seen_in = 1'b1;
                  free_pos_in  = pos_ff;
               end
               pos_in            = next_pos;
               probe_cnt_in      = probe_cnt_ff + 1'b1;
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = next_pos;
            end
            if (state_in == ST_IDLE) begin
               rsp_valid_in        = 1'b1;
               rsp_in.member_count = count_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         zero_ff      <= 1'b0;
         one_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         free_seen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zero_ff      <= zero_in;
         one_ff       <= one_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         free_seen_ff <= free_seen_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      pos_ff       <= pos_in;
      step_ff      <= step_in;
      probe_cnt_ff <= probe_cnt_in;
      free_pos_ff  <= free_pos_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // A response only appears once the probe walk has closed.
   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while a probe walk is open");

   // Every taken request either answers at once or opens a probe walk.
   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy))
      else $error("request taken without response or probe walk");

   // The member count moves by at most one per cycle.
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      ##1 (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1 ||
           count_ff == $past(count_ff) - 1'b1))
      else $error("member count jumped");

   // The store is written only at the close of a probe walk.
   a_write_closes_walk : assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |=> (!busy && rsp_strobe))
      else $error("slot store written outside the close of a probe walk");

endmodule

@@ bench/open_addressing_hash_set_tb.sv @@
`timescale 1ns / 100ps

import ohs_pkg::*;

class hash_set_scoreboard;

   typedef struct {
      req_type request;
      rsp_type answer;
   } pending_answer_type;

   logic [KEY_W-1:0]   slots [TABLE_SIZE];
   bit                 zero_held;
   bit                 one_held;
   int unsigned        held;
   pending_answer_type answers_due [$];
   int unsigned        errors;

   function new();
      foreach (slots[i]) slots[i] = SLOT_EMPTY;
      zero_held = 1'b0;
      one_held  = 1'b0;
      held      = 0;
      errors    = 0;
   endfunction

   // Walks the probe path of a key (2 or more) and stops at the key or at the first empty slot.
   function bit find_key(logic [KEY_W-1:0] k, output logic [ADDR_W-1:0] where);
      logic [ADDR_W-1:0] pos;
      logic [ADDR_W-1:0] stride;
      pos    = k[ADDR_W-1:0];
      stride = {k[ADDR_W-2:0], 1'b1};
      where  = pos;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (slots[pos] == SLOT_EMPTY) return 1'b0;
         if (slots[pos] == k) begin
            where = pos;
            return 1'b1;
         end
         pos = pos + stride;
      end
      return 1'b0;
   endfunction

   function bit apply_op(logic [1:0] op, logic [KEY_W-1:0] k);
      logic [ADDR_W-1:0] pos;
      logic [ADDR_W-1:0] stride;
      if (op == OP_LOOKUP) begin
         if (held == 0) return 1'b0;
         if (k == 0) return zero_held;
         if (k == 1) return one_held;
         return find_key(k, pos);
      end
      if (op == OP_INSERT) begin
         if (k == 0) begin
            if (!zero_held) begin
               zero_held = 1'b1;
               held++;
            end
            return 1'b1;
         end
         if (k == 1) begin
            if (!one_held) begin
               one_held = 1'b1;
               held++;
            end
            return 1'b1;
         end
         if (held != 0 && find_key(k, pos)) return 1'b1;
         pos    = k[ADDR_W-1:0];
         stride = {k[ADDR_W-2:0], 1'b1};
         for (int i = 0; i < TABLE_SIZE; i++) begin
            if (slots[pos] == SLOT_EMPTY || slots[pos] == SLOT_VACATED) begin
               slots[pos] = k;
               held++;
               return 1'b1;
            end
            pos = pos + stride;
         end
         return 1'b0;
      end
      if (op == OP_REMOVE) begin
         if (held == 0) return 1'b0;
         if (k == 0) begin
            if (!zero_held) return 1'b0;
            zero_held = 1'b0;
            held--;
            return 1'b1;
         end
         if (k == 1) begin
            if (!one_held) return 1'b0;
            one_held = 1'b0;
            held--;
            return 1'b1;
         end
         if (!find_key(k, pos)) return 1'b0;
         slots[pos] = SLOT_VACATED;
         held--;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function void note_request(req_type r);
      pending_answer_type p;
      p.request             = r;
      p.answer.success      = apply_op(r.opcode, r.key);
      p.answer.member_count = COUNT_W'(held);
      answers_due.push_back(p);
   endfunction

   function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endfunction

   function void check_response(rsp_type got);
      pending_answer_type p;
      if (answers_due.size() == 0) begin
         report($sformatf("response %0b/%0d with no request outstanding",
                          got.success, got.member_count));
         return;
      end
      p = answers_due.pop_front();
      if (got.success !== p.answer.success)
         report($sformatf("op %0d key %h: success expected %0b got %0b",
                          p.request.opcode, p.request.key, p.answer.success, got.success));
      if (got.member_count !== p.answer.member_count)
         report($sformatf("op %0d key %h: member_count expected %0d got %0d",
                          p.request.opcode, p.request.key, p.answer.member_count,
                          got.member_count));
   endfunction

   function int pending();
      return answers_due.size();
   endfunction

   function bit table_full();
      return (held - zero_held - one_held) == TABLE_SIZE;
   endfunction

endclass

module open_addressing_hash_set_tb;

   // Opcode 3 has no member in the package enum; the block must answer it
   // without touching the set.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // The slowest request is a miss on a table with no empty slot: a single
   // probe walk sweeps all slots, looking for the key and for room at once.
   // Nothing else keeps the request and response channels quiet this long.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 600;
   localparam int POOL_DEPTH     = 96;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   hash_set_scoreboard board = new();

   // Keys inserted lately; revisiting them is what makes lookups and removes hit.
   logic [KEY_W-1:0] key_pool [$];
   int               burst_left = 0;
   int               quiet_cycles = 0;

   open_addressing_hash_set dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Every response is taken at the edge that closes its strobe cycle; the
   // receiver has no way to push back, so there is nothing to stall here.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_response(rsp_data);
   end

   // The watchdog counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("open_addressing_hash_set_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a rising edge. Raises start with the request and returns at the
   // edge that takes it, with start still high so that a following request
   // can go out back to back.
   task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] k);
      start    <= 1'b1;
      req_data <= '{opcode: op, key: k};
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(req_data);
      if (op == OP_INSERT && k > 1) begin
         key_pool.push_back(k);
         if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end
   endtask

   // The sender works in bursts. Gap lengths are unrelated to the length of
   // the probe walk, so pauses land on every phase of the block's work; a
   // zero gap joins two bursts into one longer busy stretch.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic issue(input logic [1:0] op, input logic [KEY_W-1:0] k);
      send_request(op, k);
      pace();
   endtask

   // Holds the sender off until every response owed has come back.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() > 0);
   endtask

   function automatic logic [1:0] pick_op(int insert_w, int lookup_w, int remove_w);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < insert_w) return OP_INSERT;
      if (sel < insert_w + lookup_w) return OP_LOOKUP;
      if (sel < insert_w + lookup_w + remove_w) return OP_REMOVE;
      return OP_UNUSED;
   endfunction

   // Keys come from a mix of sources: fully random words, the two flag keys
   // and their neighbors, keys seen before, and a clustered family whose few
   // low bytes make many keys share one probe path.
   function automatic logic [KEY_W-1:0] pick_key();
      int         sel;
      logic [7:0] low;
      sel = $urandom_range(0, 99);
      if (sel < 10) return $urandom();
      if (sel < 16) return KEY_W'($urandom_range(0, 3));
      if (sel < 55 && key_pool.size() > 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      low = 8'($urandom_range(0, 7)) * 8'h25;
      return ($urandom() & 32'hC000_0300) | {24'h0, low};
   endfunction

   initial begin
      int               fill_guard;
      logic [KEY_W-1:0] k;

      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: the empty set, the flag keys, a chain of keys that
      // share a probe path, a vacated slot passed over and then reused, the
      // unused opcode, and keys at both ends of the range.
      send_request(OP_LOOKUP, 32'h0000_0000);
      send_request(OP_REMOVE, 32'h0000_0005);
      send_request(OP_UNUSED, 32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h0000_0001);
      send_request(OP_REMOVE, 32'h0000_0001);
      send_request(OP_INSERT, 32'h0000_0001);
      send_request(OP_INSERT, 32'h0000_0002);
      send_request(OP_INSERT, 32'h0000_0102);
      send_request(OP_INSERT, 32'hFFFF_FF02);
      send_request(OP_LOOKUP, 32'h0000_0102);
      send_request(OP_REMOVE, 32'h0000_0002);
      send_request(OP_LOOKUP, 32'hFFFF_FF02);
      send_request(OP_INSERT, 32'h0000_0202);
      send_request(OP_INSERT, 32'h0000_0102);
      send_request(OP_REMOVE, 32'h0000_0002);
      send_request(OP_UNUSED, 32'h1234_5678);
      send_request(OP_INSERT, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h8000_0000);
      send_request(OP_REMOVE, 32'h0000_0000);
      send_request(OP_REMOVE, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h0000_0000);
      send_request(OP_REMOVE, 32'h0000_0001);
      drain();

      // Mixed traffic on a moderately loaded table, with one pause in the
      // middle that lets every response come home first.
      for (int i = 0; i < 520; i++) begin
         if (i == 260) drain();
         issue(pick_op(40, 30, 25), pick_key());
      end

      // Fill every slot with fresh keys. Each new key finds room because an
      // odd stride visits every slot of a power-of-two table.
      fill_guard = 0;
      while (!board.table_full() && fill_guard < 1000) begin
         issue(OP_INSERT, $urandom());
         fill_guard++;
      end

      // A full table: inserts with no room, lookups that sweep every slot,
      // the flag keys pushing the count to its top, and removes that open a
      // vacated slot for the next insert to take.
      for (int i = 0; i < 60; i++) begin
         case ($urandom_range(0, 5))
            0: begin
               issue(OP_INSERT, $urandom());
            end
            1: begin
               issue(OP_LOOKUP, $urandom());
            end
            2: begin
               issue(OP_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)]);
            end
            3: begin
               issue(OP_INSERT, KEY_W'($urandom_range(0, 1)));
            end
            4: begin
               issue(OP_REMOVE, KEY_W'($urandom_range(0, 1)));
            end
            default: begin
               k = key_pool[$urandom_range(0, key_pool.size() - 1)];
               issue(OP_REMOVE, k);
               issue(OP_INSERT, $urandom());
            end
         endcase
      end

      // Mostly removes and lookups on a table with no empty slot left, so that every
      // miss on a key of 2 or more walks the whole probe path over vacated slots.
      for (int i = 0; i < 240; i++) begin
         issue(pick_op(20, 35, 40), pick_key());
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() > 0)
         $display("%0d responses never arrived", board.pending());
      if (board.errors == 0 && board.pending() == 0) begin
         $display("open_addressing_hash_set_tb: PASS");
      end else begin
         $display("open_addressing_hash_set_tb: FAIL");
      end
      $finish;
   end

endmodule
